// ----- sv/rtc3w_pkg.sv -----
`default_nettype none

package rtc3w_pkg;

  // Longest burst, in data bytes after the command byte.
  localparam int MaxBurst = 8;
  localparam int BurstW   = $clog2(MaxBurst + 1);

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2,
    OpSpare = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    PhIdle = 3'd0,
    PhCmd  = 3'd1,
    PhWr   = 3'd2,
    PhRd   = 3'd3,
    PhEnd  = 3'd4
  } phase_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] command;
    logic [7:0] write_data;
    logic [3:0] byte_count;
    logic       io_in;
  } in_beat_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       need_byte;
    logic       busy_res;
  } out_beat_t;

endpackage

`default_nettype wire

// ----- sv/three_wire_rtc_serial_master.sv -----
`default_nettype none

// Three-wire serial master for a real-time-clock chip. Every input beat is one
// half-bit tick of the serial link and yields exactly one output beat with the
// pin levels for that tick (chip enable, serial clock, data out and drive
// enable) plus read-data and write-data handshake flags. An opcode of write or
// read while idle starts a transaction: the command byte goes out LSB first
// (data set with the clock low, latched by the slave on the rising edge), then
// byte_count data bytes follow, clamped to one at the low end and to MaxBurst
// at the high end. During writes, need_byte marks the tick on which write_data
// is consumed; during reads the data pin is released and read_valid marks the
// tick on which read_byte is complete, with read_last on the final byte. A
// closing tick keeps chip enable high with the clock low, then chip enable
// drops. Starts that arrive while busy are ignored. The block takes one beat
// per clock: the tick logic sits between the state registers and a single
// output register, and a new beat is accepted whenever that register is empty
// or being drained in the same cycle.
module three_wire_rtc_serial_master
  import rtc3w_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o
);

  // Transaction state.
  phase_e              phase_q, phase_d;
  logic [7:0]          shift_q, shift_d;
  logic [2:0]          bit_idx_q, bit_idx_d;
  logic                half_q, half_d;
  logic [BurstW-1:0]   left_q, left_d;
  logic                is_read_q, is_read_d;

  // Output register.
  logic                out_valid_q;
  out_beat_t           out_q, out_d;

  logic                in_fire;

  // The output register can take a new beat when it is empty or is being
  // emptied this cycle, so a stalled consumer only stalls us once it backs up.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    bit_idx_d = bit_idx_q;
    half_d    = half_q;
    left_d    = left_q;
    is_read_d = is_read_q;

    out_d              = '0;
    out_d.io_drive     = 1'b1;

    // A start while idle loads the command and falls straight into the
    // first clock-low tick of command bit 0.
    if (phase_d == PhIdle &&
        (in_data_i.opcode == OpWrite || in_data_i.opcode == OpRead)) begin
      phase_d   = PhCmd;
      shift_d   = in_data_i.command;
      bit_idx_d = '0;
      half_d    = 1'b0;
      is_read_d = (in_data_i.opcode == OpRead);
      if (in_data_i.byte_count == '0) begin
        left_d = BurstW'(1);
      end else if (32'(in_data_i.byte_count) > MaxBurst) begin
        left_d = BurstW'(MaxBurst);
      end else begin
        left_d = BurstW'(in_data_i.byte_count);
      end
    end

    unique case (phase_d)
      PhCmd: begin
        out_d.chip_enable = 1'b1;
        out_d.busy_res    = 1'b1;
        out_d.io_out      = shift_d[0];
        if (!half_d) begin
          half_d = 1'b1;
        end else begin
          out_d.serial_clock = 1'b1;
          half_d             = 1'b0;
          shift_d            = shift_d >> 1;
          if (bit_idx_d == 3'd7) begin
            bit_idx_d = '0;
            shift_d   = '0;
            phase_d   = is_read_d ? PhRd : PhWr;
          end else begin
            bit_idx_d = bit_idx_d + 3'd1;
          end
        end
      end
      PhWr: begin
        out_d.chip_enable = 1'b1;
        out_d.busy_res    = 1'b1;
        if (!half_d) begin
          if (bit_idx_d == '0) begin
            shift_d         = in_data_i.write_data;
            out_d.need_byte = 1'b1;
          end
          out_d.io_out = shift_d[0];
          half_d       = 1'b1;
        end else begin
          out_d.serial_clock = 1'b1;
          out_d.io_out       = shift_d[0];
          shift_d            = shift_d >> 1;
          half_d             = 1'b0;
          if (bit_idx_d == 3'd7) begin
            bit_idx_d = '0;
            if (left_d <= BurstW'(1)) begin
              left_d  = '0;
              phase_d = PhEnd;
            end else begin
              left_d = left_d - BurstW'(1);
            end
          end else begin
            bit_idx_d = bit_idx_d + 3'd1;
          end
        end
      end
      PhRd: begin
        out_d.chip_enable = 1'b1;
        out_d.busy_res    = 1'b1;
        out_d.io_drive    = 1'b0;
        if (!half_d) begin
          // Sample on the clock-low tick; bits enter at the top so the byte
          // lines up LSB first after eight samples.
          shift_d = {in_data_i.io_in, shift_d[7:1]};
          if (bit_idx_d == 3'd7) begin
            out_d.read_valid = 1'b1;
            out_d.read_byte  = shift_d;
            out_d.read_last  = (left_d <= BurstW'(1));
          end
          half_d = 1'b1;
        end else begin
          out_d.serial_clock = 1'b1;
          half_d             = 1'b0;
          if (bit_idx_d == 3'd7) begin
            bit_idx_d = '0;
            if (left_d <= BurstW'(1)) begin
              left_d  = '0;
              phase_d = PhEnd;
            end else begin
              left_d = left_d - BurstW'(1);
            end
          end else begin
            bit_idx_d = bit_idx_d + 3'd1;
          end
        end
      end
      PhEnd: begin
        // Closing tick: chip enable still high, clock low, data driven low.
        out_d.chip_enable = 1'b1;
        out_d.busy_res    = 1'b1;
        phase_d           = PhIdle;
        bit_idx_d         = '0;
        half_d            = 1'b0;
        left_d            = '0;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      shift_q     <= '0;
      bit_idx_q   <= '0;
      half_q      <= 1'b0;
      left_q      <= '0;
      is_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        shift_q     <= shift_d;
        bit_idx_q   <= bit_idx_d;
        half_q      <= half_d;
        left_q      <= left_d;
        is_read_q   <= is_read_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  // Between transactions no byte count is left over.
  a_idle_no_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (left_q == '0))
    else $error("idle with bytes left");

  // A read byte only completes while the data pin is released.
  a_read_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.read_valid) |-> (!out_q.io_drive && out_q.chip_enable))
    else $error("read byte while driving data pin");

  // Write data is only taken with the pin driven and the clock low.
  a_need_byte_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.need_byte) |->
      (out_q.io_drive && !out_q.serial_clock && out_q.chip_enable))
    else $error("write byte requested outside a clock-low write tick");

  // The serial clock never toggles outside chip enable.
  a_clock_in_ce : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.serial_clock) |-> out_q.chip_enable)
    else $error("serial clock high without chip enable");

  // The first tick after a start from idle is a clock-low command tick.
  a_start_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PhIdle &&
     (in_data_i.opcode == OpWrite || in_data_i.opcode == OpRead)) |=>
      (phase_q == PhCmd && half_q && out_q.chip_enable && !out_q.serial_clock))
    else $error("start did not enter command phase");

endmodule

`default_nettype wire
